// ===== sv/multi_mode_branch_predictor_macros.svh =====
// assertion helpers shared by the predictor rtl
`ifndef MULTI_MODE_BRANCH_PREDICTOR_MACROS_SVH
`define MULTI_MODE_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MMBP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MMBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mmbp_pkg.sv =====
// ---------------------------------------------------------------------------
// mmbp_pkg
// types, codes and small helpers of the multi-mode branch predictor
// ---------------------------------------------------------------------------
package mmbp_pkg;

	typedef enum logic [2:0] {
		MODE_NEVER  = 3'd0,
		MODE_ALWAYS = 3'd1,
		MODE_BTFN   = 3'd2,
		MODE_ONEBIT = 3'd3,
		MODE_TWOBIT = 3'd4,
		MODE_GSHARE = 3'd5,
		MODE_TOURN  = 3'd6
	} mode_t;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 5;
	localparam int HLEN_W    = 5;
	localparam int HIST_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HLEN = 1'b1;

	localparam logic [HLEN_W-1:0] HLEN_RESET = 5'd8;
	localparam logic [HLEN_W-1:0] HLEN_MAX   = 5'd16;

	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;

	localparam int CHOOSER_BIT = 8;

	localparam logic       SBIT_RESET = 1'b0;
	localparam logic [1:0] CTR_RESET  = 2'd1;
	localparam logic [1:0] CTR_MAX    = 2'd3;
	localparam logic [1:0] CTR_MIN    = 2'd0;

	// write-back request from the update logic to the tables
	typedef struct packed {
		logic       l_en;
		logic       g_en;
		logic       sbit;
		logic [1:0] bim;
		logic [1:0] gctr;
	} tbl_wr_t;

	function automatic logic [1:0] bump(input logic [1:0] ctr, input logic up);
		logic [1:0] res;
		if (up) begin
			res = (ctr == CTR_MAX) ? ctr : ctr + 2'd1;
		end else begin
			res = (ctr == CTR_MIN) ? ctr : ctr - 2'd1;
		end
		return res;
	endfunction

	function automatic logic is_cti(input logic [6:0] opc);
		return opc inside {OPC_BRANCH, OPC_JAL, OPC_JALR};
	endfunction

endpackage

// ===== sv/mmbp_tables.sv =====
// ---------------------------------------------------------------------------
// mmbp_tables
// local table (one-bit + bimodal counter) and gshare counter memories,
// with the clearing pass that follows reset
// ---------------------------------------------------------------------------
module mmbp_tables import mmbp_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] l_raddr,
	input  logic [$clog2(TABLE_DEPTH)-1:0] g_raddr,
	input  logic [$clog2(TABLE_DEPTH)-1:0] l_waddr,
	input  logic [$clog2(TABLE_DEPTH)-1:0] g_waddr,
	input  tbl_wr_t                        wr,
	output logic                           clearing,
	output logic                           rd_sbit,
	output logic [1:0]                     rd_bim,
	output logic [1:0]                     rd_gctr
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [2:0] mem_l [TABLE_DEPTH];
	logic [1:0] mem_g [TABLE_DEPTH];

	logic             clr_active_q;
	logic [IDX_W-1:0] clr_idx_q;

	logic             l_we;
	logic             g_we;
	logic [IDX_W-1:0] l_addr;
	logic [IDX_W-1:0] g_addr;
	logic [2:0]       l_wdata;
	logic [1:0]       g_wdata;
	logic [2:0]       l_rdata_q;
	logic [1:0]       g_rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == {IDX_W{1'b1}}) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// the clearing pass owns the write port until it is done
	always_comb begin
		if (clr_active_q) begin
			l_we    = 1'b1;
			g_we    = 1'b1;
			l_addr  = clr_idx_q;
			g_addr  = clr_idx_q;
			l_wdata = {SBIT_RESET, CTR_RESET};
			g_wdata = CTR_RESET;
		end else begin
			l_we    = wr.l_en;
			g_we    = wr.g_en;
			l_addr  = l_waddr;
			g_addr  = g_waddr;
			l_wdata = {wr.sbit, wr.bim};
			g_wdata = wr.gctr;
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			mem_l[l_addr] <= l_wdata;
		end
		if (g_we) begin
			mem_g[g_addr] <= g_wdata;
		end
		if (rd_en) begin
			l_rdata_q <= mem_l[l_raddr];
			g_rdata_q <= mem_g[g_raddr];
		end
	end

	assign clearing = clr_active_q;
	assign rd_sbit  = l_rdata_q[2];
	assign rd_bim   = l_rdata_q[1:0];
	assign rd_gctr  = g_rdata_q;

endmodule

// ===== sv/multi_mode_branch_predictor.sv =====
// ---------------------------------------------------------------------------
// multi_mode_branch_predictor
// seven-mode direction predictor: static, one-bit, bimodal, gshare, tournament
// ---------------------------------------------------------------------------
// a request is taken at a clock edge with start high and busy low; op picks a
// predict (pc, instruction) or an update (pc, taken). every request returns
// one result: done is high for one cycle with prediction, total_count and
// correct_count; the receiver cannot hold it off.
// the table memories are read at the accepting edge and written back at the
// next one, and done rises at that write-back edge.
// busy is high during the write-back cycle, so a new request is not taken while
// one is in flight; the earliest start after done's cycle begins is that cycle.
// after reset the tables are swept to their initial values, one entry a
// cycle, until every entry is written; busy stays high during the sweep. the
// configuration port (cfg_we, cfg_index, cfg_data) writes mode and
// history_length at any edge; write it only while no request is in flight.
// TABLE_DEPTH must be a power of two.
// ---------------------------------------------------------------------------
`include "multi_mode_branch_predictor_macros.svh"

module multi_mode_branch_predictor import mmbp_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [31:0]          pc,
	input  logic [31:0]          instruction,
	input  logic                 taken,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 done,
	output logic                 prediction,
	output logic [31:0]          total_count,
	output logic [31:0]          correct_count
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic accept;
	logic clearing;

	mode_t             mode_q;
	logic [HLEN_W-1:0] hlen_q;
	logic [HIST_W-1:0] hist_q;
	logic [31:0]       total_q;
	logic [31:0]       correct_q;
	logic              done_q;
	logic              pred_q;

	logic [IDX_W-1:0] li_s0;
	logic [IDX_W-1:0] gi_s0;

	logic             valid_s1;
	logic             op_s1;
	logic             cti_s1;
	logic             sign_s1;
	logic             taken_s1;
	logic             chooser_s1;
	logic [IDX_W-1:0] li_s1;
	logic [IDX_W-1:0] gi_s1;

	logic       rd_sbit;
	logic [1:0] rd_bim;
	logic [1:0] rd_gctr;

	tbl_wr_t           wr_req;
	tbl_wr_t           wr;
	logic              pred_d;
	logic              ok;
	logic              shift;
	logic              count_pred;
	logic [HLEN_W-1:0] hlen_c;
	logic [HIST_W:0]   hmask_full;
	logic [HIST_W-1:0] hmask;

	assign busy   = clearing | valid_s1;
	assign accept = start & ~busy;

	assign li_s0 = pc[IDX_W+1:2];
	assign gi_s0 = pc[IDX_W+1:2] ^ hist_q[IDX_W-1:0];

	mmbp_tables #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_tables (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.l_raddr  (li_s0),
		.g_raddr  (gi_s0),
		.l_waddr  (li_s1),
		.g_waddr  (gi_s1),
		.wr       (wr),
		.clearing (clearing),
		.rd_sbit  (rd_sbit),
		.rd_bim   (rd_bim),
		.rd_gctr  (rd_gctr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NEVER;
			hlen_q <= HLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= mode_t'(cfg_data[2:0]);
				REG_HLEN: hlen_q <= cfg_data[HLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op;
			cti_s1     <= is_cti(instruction[6:0]);
			sign_s1    <= instruction[31];
			taken_s1   <= taken;
			chooser_s1 <= pc[CHOOSER_BIT];
			li_s1      <= li_s0;
			gi_s1      <= gi_s0;
		end
	end

	// decide the outcome from the words read at the accepting edge
	always_comb begin
		pred_d     = 1'b0;
		ok         = 1'b0;
		shift      = 1'b0;
		count_pred = 1'b0;
		wr_req     = '{l_en: 1'b0, g_en: 1'b0, sbit: rd_sbit, bim: rd_bim, gctr: rd_gctr};
		if (op_s1 == OP_PREDICT) begin
			if (cti_s1) begin
				count_pred = 1'b1;
				case (mode_q)
					MODE_ALWAYS: pred_d = 1'b1;
					MODE_BTFN:   pred_d = sign_s1;
					MODE_ONEBIT: pred_d = rd_sbit;
					MODE_TWOBIT: pred_d = rd_bim[1];
					MODE_GSHARE: pred_d = rd_gctr[1];
					MODE_TOURN:  pred_d = chooser_s1 ? rd_gctr[1] : rd_bim[1];
					default:     pred_d = 1'b0;
				endcase
			end
		end else begin
			case (mode_q)
				MODE_NEVER:  ok = ~taken_s1;
				MODE_ALWAYS: ok = taken_s1;
				MODE_BTFN:   ok = ~taken_s1;
				MODE_ONEBIT: begin
					ok          = (rd_sbit == taken_s1);
					wr_req.l_en = 1'b1;
					wr_req.sbit = taken_s1;
				end
				MODE_TWOBIT: begin
					ok          = (rd_bim[1] == taken_s1);
					wr_req.l_en = 1'b1;
					wr_req.bim  = bump(rd_bim, taken_s1);
				end
				MODE_GSHARE: begin
					ok          = (rd_gctr[1] == taken_s1);
					wr_req.g_en = 1'b1;
					wr_req.gctr = bump(rd_gctr, taken_s1);
					shift       = 1'b1;
				end
				MODE_TOURN: begin
					ok          = (rd_bim[1] == taken_s1) | (rd_gctr[1] == taken_s1);
					wr_req.l_en = 1'b1;
					wr_req.g_en = 1'b1;
					wr_req.bim  = bump(rd_bim, taken_s1);
					wr_req.gctr = bump(rd_gctr, taken_s1);
					shift       = 1'b1;
				end
				default: ok = 1'b0;
			endcase
		end
	end

	always_comb begin
		wr      = wr_req;
		wr.l_en = wr_req.l_en & valid_s1;
		wr.g_en = wr_req.g_en & valid_s1;
	end

	// lengths above the history width act as the full width
	assign hlen_c     = (hlen_q > HLEN_MAX) ? HLEN_MAX : hlen_q;
	assign hmask_full = ({{HIST_W{1'b0}}, 1'b1} << hlen_c) - {{HIST_W{1'b0}}, 1'b1};
	assign hmask      = hmask_full[HIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q    <= '0;
			total_q   <= '0;
			correct_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				if (shift) begin
					hist_q <= {hist_q[HIST_W-2:0], taken_s1} & hmask;
				end
				if (count_pred) begin
					total_q <= total_q + 32'd1;
				end
				if (ok) begin
					correct_q <= correct_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pred_q <= pred_d;
		end
	end

	assign done          = done_q;
	assign prediction    = pred_q;
	assign total_count   = total_q;
	assign correct_count = correct_q;

	`MMBP_ASSERT_NEXT(a_done_after_work, valid_s1, done, "result strobe missing after request")
	`MMBP_ASSERT_NOW(a_no_accept_clearing, clearing, busy, "busy low during table sweep")
	`MMBP_ASSERT_NEXT(a_update_keeps_total, valid_s1 && (op_s1 == OP_UPDATE),
		$stable(total_count), "update changed prediction count")
	`MMBP_ASSERT_NEXT(a_hist_masked, valid_s1 && shift && !cfg_we,
		(hist_q & ~hmask) == '0, "history holds bits above its length")

endmodule
